// ===== design/frc_pkg.sv =====
// Types and constants shared by the feedback rate controller files.
`default_nettype none

package frc_pkg;

   localparam int OCC_W  = 24;
   localparam int PKT_W  = 11;
   localparam int RATE_W = 32;
   localparam int GAM_W  = 16;
   localparam int STEP_W = 24;
   localparam int DEC_W  = 17;
   localparam int GAIN_W = 20;

   // multiplier operands and product
   localparam int MA_W = 35;
   localparam int MB_W = 21;
   localparam int MP_W = MA_W + MB_W;
   localparam int LAW_W = MP_W - 16;
   // width of the exact sum before clipping
   localparam int SUM_W = 58;

   localparam logic [PKT_W-1:0] MAX_PACKET = 11'd1488;

   localparam logic [1:0] MODE_ADD  = 2'd0;
   localparam logic [1:0] MODE_MULT = 2'd1;
   localparam logic [1:0] MODE_PROP = 2'd2;
   localparam logic [1:0] MODE_RATE = 2'd3;

   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_STEP      = 3'd1;
   localparam logic [2:0] CSR_DECREASE  = 3'd2;
   localparam logic [2:0] CSR_OCC_GAIN  = 3'd3;
   localparam logic [2:0] CSR_RATE_GAIN = 3'd4;
   localparam logic [2:0] CSR_PACKET    = 3'd5;
   localparam logic [2:0] CSR_INIT_RATE = 3'd6;

   localparam logic [STEP_W-1:0] RESET_STEP      = 24'd65536;
   localparam logic [DEC_W-1:0]  RESET_DECREASE  = 17'd32768;
   localparam logic [GAIN_W-1:0] RESET_OCC_GAIN  = 20'd13107;
   localparam logic [GAIN_W-1:0] RESET_RATE_GAIN = 20'd32768;
   localparam logic [PKT_W-1:0]  RESET_PACKET    = 11'd1024;
   localparam logic [RATE_W-1:0] RESET_RATE      = 32'd6553600;

   typedef struct packed {
      logic [OCC_W-1:0] occupancy;
      logic [OCC_W-1:0] target_occupancy;
      logic [GAM_W-1:0] target_rate;
   } req_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] new_rate;
      logic                     saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_STEP,
      ST_MUL_LAW,
      ST_SCALE,
      ST_SUM
   } state_type;

endpackage

`default_nettype wire

// ===== design/frc_div.sv =====
// Restoring divider, one quotient bit per cycle, for occupancy error over packet size.
`default_nettype none

module frc_div
   import frc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [OCC_W-1:0] dividend,
   input  wire logic [PKT_W-1:0] divisor,
   output logic                  done,
   output logic      [OCC_W-1:0] quotient
);

   localparam int CNT_W = $clog2(OCC_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PKT_W-1:0] den_ff;
   logic [PKT_W-1:0] rem_ff;
   logic [PKT_W-1:0] rem_in;
   logic [OCC_W-1:0] quo_ff;
   logic [OCC_W-1:0] quo_in;
   logic [PKT_W:0]   trial;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[OCC_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? PKT_W'(trial - {1'b0, den_ff}) : trial[PKT_W-1:0];
      quo_in = {quo_ff[OCC_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(OCC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/feedback_rate_controller_core.sv =====
// Top level of the feedback rate controller: registers, sequencer and shared multiplier.
//
//   channel  direction  handshake          word
//   req      in         req_valid/stall    req_type (occupancy, target, target rate)
//   rsp      out        rsp_valid/stall    rsp_type (new rate, saturated)
//   csr      in         csr_valid/ready    3-bit index, 32-bit data
//
// A word passes from acceptance to result through the bit-serial divider, the
// two passes through the shared multiplier, the scaling step, and the sum and
// clip, with a divider hand-over between divide and multiply. req_stall is high
// throughout. The output register holds a result under rsp_stall while the next
// word is taken; a finished sum waits only if that register is still full.
// Synchronous reset restores the registers and the rate to their reset values.
`default_nettype none

module feedback_rate_controller_core
   import frc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   state_type state_ff, state_in;

   logic [1:0]        mode_ff;
   logic [STEP_W-1:0] step_size_ff;
   logic [DEC_W-1:0]  decrease_ff;
   logic [GAIN_W-1:0] occ_gain_ff;
   logic [GAIN_W-1:0] rate_gain_ff;
   logic [PKT_W-1:0]  packet_ff;
   logic signed [RATE_W-1:0] rate_ff;

   logic             gt_ff, lt_ff, neg_ff;
   logic [GAM_W-1:0] gamma_ff;
   logic signed [MP_W-1:0]  step_ff;
   logic signed [MP_W-1:0]  prod_ff;
   logic signed [LAW_W-1:0] law_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic             req_take, rsp_take, csr_take, out_load;
   logic [OCC_W-1:0] err_mag;
   logic [PKT_W-1:0] divisor;
   logic             div_done;
   logic [OCC_W-1:0] quo;
   logic signed [OCC_W:0]   q;
   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [MP_W-1:0]  mul_p;
   logic signed [MP_W-1:0]  rounded;
   logic signed [SUM_W-1:0] cur_x, inc, dec, padd, next;
   logic                    sat_hi, sat_lo;
   rsp_type                 result;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   // magnitude of the occupancy error, sign applied after the divide
   always_comb begin
      if (req_data.occupancy > req_data.target_occupancy)
         err_mag = req_data.occupancy - req_data.target_occupancy;
      else
         err_mag = req_data.target_occupancy - req_data.occupancy;
      if (packet_ff == '0)
         divisor = PKT_W'(1);
      else if (packet_ff > MAX_PACKET)
         divisor = MAX_PACKET;
      else
         divisor = packet_ff;
   end

   frc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take),
      .dividend (err_mag),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quo)
   );

   assign q = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   // shared multiplier: occupancy gain times quotient, then the law's product
   always_comb begin
      if (state_ff == ST_MUL_STEP) begin
         mul_a = MA_W'(q);
         mul_b = $signed({1'b0, occ_gain_ff});
      end else if (mode_ff == MODE_MULT) begin
         mul_a = MA_W'(rate_ff);
         mul_b = $signed({{(MB_W-DEC_W){1'b0}}, decrease_ff});
      end else begin
         mul_a = MA_W'(rate_ff) - $signed({{(MA_W-GAM_W-16){1'b0}}, gamma_ff, 16'd0});
         mul_b = $signed({1'b0, rate_gain_ff});
      end
      mul_p = mul_a * mul_b;
   end

   // truncation toward zero on the way back to Q16.16
   assign rounded = prod_ff + (prod_ff[MP_W-1] ? MP_W'(65535) : MP_W'(0));

   always_comb begin
      cur_x = SUM_W'(rate_ff);
      inc   = cur_x + $signed({{(SUM_W-STEP_W){1'b0}}, step_size_ff});
      dec   = cur_x - $signed({{(SUM_W-STEP_W){1'b0}}, step_size_ff});
      padd  = cur_x + SUM_W'(step_ff);
      unique case (mode_ff)
         MODE_ADD: begin
            if (gt_ff)
               next = (dec > 0) ? dec : cur_x;
            else if (lt_ff)
               next = inc;
            else
               next = cur_x;
         end
         MODE_MULT: begin
            if (gt_ff)
               next = SUM_W'(law_ff);
            else if (lt_ff)
               next = inc;
            else
               next = cur_x;
         end
         MODE_PROP: next = (padd > 0) ? padd : cur_x;
         default:   next = padd - SUM_W'(law_ff);
      endcase
      sat_hi = !next[SUM_W-1] && (next[SUM_W-2:RATE_W-1] != '0);
      sat_lo = next[SUM_W-1] && (next[SUM_W-2:RATE_W-1] != '1);
      result.saturated = sat_hi || sat_lo;
      if (sat_hi)
         result.new_rate = 32'sh7fffffff;
      else if (sat_lo)
         result.new_rate = 32'sh80000000;
      else
         result.new_rate = next[RATE_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:     if (req_take) state_in = ST_DIV;
         ST_DIV:      if (div_done) state_in = ST_MUL_STEP;
         ST_MUL_STEP: state_in = ST_MUL_LAW;
         ST_MUL_LAW:  state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_SUM;
         ST_SUM: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // configuration and rate state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ADD;
         step_size_ff <= RESET_STEP;
         decrease_ff  <= RESET_DECREASE;
         occ_gain_ff  <= RESET_OCC_GAIN;
         rate_gain_ff <= RESET_RATE_GAIN;
         packet_ff    <= RESET_PACKET;
         rate_ff      <= RESET_RATE;
      end else begin
         if (out_load)
            rate_ff <= result.new_rate;
         if (csr_take) begin
            unique case (csr_index)
               CSR_MODE:      mode_ff      <= csr_data[1:0];
               CSR_STEP:      step_size_ff <= csr_data[STEP_W-1:0];
               CSR_DECREASE:  decrease_ff  <= csr_data[DEC_W-1:0];
               CSR_OCC_GAIN:  occ_gain_ff  <= csr_data[GAIN_W-1:0];
               CSR_RATE_GAIN: rate_gain_ff <= csr_data[GAIN_W-1:0];
               CSR_PACKET:    packet_ff    <= csr_data[PKT_W-1:0];
               CSR_INIT_RATE: rate_ff      <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         gt_ff    <= req_data.occupancy > req_data.target_occupancy;
         lt_ff    <= req_data.occupancy < req_data.target_occupancy;
         neg_ff   <= req_data.occupancy > req_data.target_occupancy;
         gamma_ff <= req_data.target_rate;
      end
      if (state_ff == ST_MUL_STEP)
         step_ff <= mul_p;
      if (state_ff == ST_MUL_LAW)
         prod_ff <= mul_p;
      if (state_ff == ST_SCALE)
         law_ff <= rounded[MP_W-1:16];
      if (out_load)
         rsp_ff <= result;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_take)
         rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== design/frc_checker.sv =====
// Port-level checks for the feedback rate controller, bound to the top level.
`default_nettype none

module frc_checker
   import frc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire req_type     req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire rsp_type     rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [2:0]  csr_index,
   input wire logic [31:0] csr_data
);

   // a held result keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

   // one word in flight: input closes straight after acceptance
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not closed after acceptance");

   // the flag only ever comes with a clipped rate
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.new_rate == 32'sh7fffffff || rsp_data.new_rate == 32'sh80000000)
      else $error("saturated flag without a clipped rate");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind feedback_rate_controller_core frc_checker u_frc_checker (.*);

`default_nettype wire
